FILE: rtl/sorted_range_region_table_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted range region table
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_REGION_TABLE_DEFINES_SVH
`define SORTED_RANGE_REGION_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SRRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/srrt_pkg.sv
// ---------------------------------------------------------------------------
// srrt_pkg
// Shared types and constants of the sorted range region table.
// ---------------------------------------------------------------------------
package srrt_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_TAG_WIDTH   = 16;
   localparam int ADDR_WIDTH          = 64;
   localparam int TAG_PORT_WIDTH      = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

endpackage

FILE: rtl/srrt_ram.sv
// ---------------------------------------------------------------------------
// srrt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sorted_range_region_table.sv
// ---------------------------------------------------------------------------
// sorted_range_region_table
// Address range table sorted by low bound: insert, remove by tag, lookup, clear.
// ---------------------------------------------------------------------------
// Lookup: each binary-search step is a RAM read (S_SRCH_RD) then a compare
//   (S_SRCH_CMP), repeated until the search range is empty.
// Insert: search, shift entries up one slot, then write. Remove: compaction pass.
// Clear: zeroes the count. One request at a time; busy stays high until the
//   result, and the result strobe is never held off by the receiver.
// Synchronous reset empties the table; no clearing pass, RAM holds no reset.
`include "sorted_range_region_table_defines.svh"

module sorted_range_region_table #(
   parameter int TABLE_DEPTH = srrt_pkg::DEFAULT_TABLE_DEPTH,
   parameter int TAG_WIDTH   = srrt_pkg::DEFAULT_TAG_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [srrt_pkg::ADDR_WIDTH-1:0]     req_range_low,
   input  logic [srrt_pkg::ADDR_WIDTH-1:0]     req_range_high,
   input  logic [srrt_pkg::TAG_PORT_WIDTH-1:0] req_region_tag,
   input  logic [srrt_pkg::ADDR_WIDTH-1:0]     req_probe_address,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic [srrt_pkg::TAG_PORT_WIDTH-1:0] rsp_hit_tag,
   output logic [srrt_pkg::ADDR_WIDTH-1:0]     rsp_hit_base,
   output logic                                rsp_status
);

   localparam int AW  = srrt_pkg::ADDR_WIDTH;
   localparam int TPW = srrt_pkg::TAG_PORT_WIDTH;
   localparam int STW = (TAG_WIDTH < TPW) ? TAG_WIDTH : TPW;
   localparam int DW  = 2 * AW + STW;
   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT, S_PUT, S_REMOVE, S_RM_END, S_CLEAR
   } state_type;

   state_type            state_ff, state_in;
   srrt_pkg::opcode_type op_ff, op_in;
   logic [AW-1:0]        key_ff, key_in, high_ff, high_in;
   logic [STW-1:0]       tag_ff, tag_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic                 cand_hit_ff, cand_hit_in;
   logic [STW-1:0]       cand_tag_ff, cand_tag_in;
   logic [AW-1:0]        cand_base_ff, cand_base_in;
   logic [CW-1:0]        ptr_ff, ptr_in, wr_ff, wr_in, pend_addr_ff, pend_addr_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_strobe_ff, rsp_strobe_in, rsp_hit_ff, rsp_hit_in;
   logic [TPW-1:0]       rsp_tag_ff, rsp_tag_in;
   logic [AW-1:0]        rsp_base_ff, rsp_base_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   logic [DW-1:0]        ram_wdata, ram_rdata;
   logic [AW-1:0]        rd_low, rd_high;
   logic [STW-1:0]       rd_tag;
   logic                 accept;

   assign rd_low  = ram_rdata[DW-1 -: AW];
   assign rd_high = ram_rdata[DW-AW-1 -: AW];
   assign rd_tag  = ram_rdata[STW-1:0];
   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   srrt_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      high_in       = high_ff;
      tag_in        = tag_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cand_hit_in   = cand_hit_ff;
      cand_tag_in   = cand_tag_ff;
      cand_base_in  = cand_base_ff;
      ptr_in        = ptr_ff;
      wr_in         = wr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_tag_in    = '0;
      rsp_base_in   = '0;
      rsp_status_in = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = ram_rdata;
      ram_raddr     = mid_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = srrt_pkg::opcode_type'(req_opcode);
               key_in      = (srrt_pkg::opcode_type'(req_opcode) == srrt_pkg::OP_INSERT)
                             ? req_range_low : req_probe_address;
               high_in     = req_range_high;
               tag_in      = req_region_tag[STW-1:0];
               lo_in       = '0;
               hi_in       = count_ff;
               cand_hit_in = 1'b0;
               ptr_in      = '0;
               wr_in       = '0;
               pend_in     = 1'b0;
               case (srrt_pkg::opcode_type'(req_opcode))
                  srrt_pkg::OP_INSERT: state_in = S_SRCH_RD;
                  srrt_pkg::OP_LOOKUP: state_in = S_SRCH_RD;
                  srrt_pkg::OP_REMOVE: state_in = S_REMOVE;
                  default:             state_in = S_CLEAR;
               endcase
            end
         end
         S_SRCH_RD: begin
            mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
            ram_raddr = mid_in[IW-1:0];
            if (op_ff == srrt_pkg::OP_INSERT && count_ff == CW'(TABLE_DEPTH)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b1;
               state_in      = S_IDLE;
            end else if (lo_ff < hi_ff) begin
               state_in = S_SRCH_CMP;
            end else if (op_ff == srrt_pkg::OP_INSERT) begin
               ptr_in   = count_ff;
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = cand_hit_ff;
               rsp_tag_in    = cand_hit_ff ? TPW'(cand_tag_ff) : '0;
               rsp_base_in   = cand_hit_ff ? cand_base_ff : '0;
               state_in      = S_IDLE;
            end
         end
         S_SRCH_CMP: begin
            // last entry stepped right over is the upper-bound predecessor
            if (key_ff < rd_low) begin
               hi_in = mid_ff;
            end else begin
               lo_in        = mid_ff + 1'b1;
               cand_hit_in  = key_ff < rd_high;
               cand_tag_in  = rd_tag;
               cand_base_in = rd_low;
            end
            state_in = S_SRCH_RD;
         end
         S_SHIFT: begin
            // read entry ptr-1 while writing the previous read one slot up
            ram_we    = pend_ff;
            ram_waddr = pend_addr_ff[IW-1:0];
            if (ptr_ff > lo_ff) begin
               ram_raddr    = IW'(ptr_ff - 1'b1);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               ptr_in       = ptr_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            ram_we        = 1'b1;
            ram_waddr     = lo_ff[IW-1:0];
            ram_wdata     = {key_ff, high_ff, tag_ff};
            count_in      = count_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_REMOVE: begin
            // compact: keep entries whose tag differs
            if (pend_ff && rd_tag != tag_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_ff[IW-1:0];
               wr_in     = wr_ff + 1'b1;
            end
            if (ptr_ff < count_ff) begin
               ram_raddr = ptr_ff[IW-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_RM_END;
            end
         end
         S_RM_END: begin
            count_in      = wr_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_CLEAR: begin
            count_in      = '0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_hit_ff    <= 1'b0;
         rsp_status_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_status_ff <= rsp_status_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      high_ff      <= high_in;
      tag_ff       <= tag_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      cand_hit_ff  <= cand_hit_in;
      cand_tag_ff  <= cand_tag_in;
      cand_base_ff <= cand_base_in;
      ptr_ff       <= ptr_in;
      wr_ff        <= wr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_base_ff  <= rsp_base_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_hit_tag  = rsp_tag_ff;
   assign rsp_hit_base = rsp_base_ff;
   assign rsp_status   = rsp_status_ff;

   `SRRT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(TABLE_DEPTH), "count above depth")
   `SRRT_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but block not busy")
   `SRRT_ASSERT_NEXT(a_single_rsp, rsp_strobe, !rsp_strobe, "back-to-back responses")
   `SRRT_ASSERT_NOW(a_status_miss, rsp_strobe && rsp_status, !rsp_hit, "status with a hit")

endmodule
